### design/sle_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted list engine.
// No dependencies; the top level and the sequencer refer to this package by scoped names.

package sle_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_INS    = 5'b00010,
        S_PUT    = 5'b00100,
        S_SCAN   = 5'b01000,
        S_REPORT = 5'b10000
    } state_t;

    localparam int RESULT_WIDTH = 32;

endpackage

### design/sorted_list_engine.sv
`timescale 1ns / 1ps
// Top level of the sorted list engine: sequencer plus entry store.
// Depends on sle_pkg, sle_mem and sle_seq.
//
// Usage:
//   A transaction is accepted at a rising edge where start is high and busy is
//   low; action and item_value are sampled then. Actions: insert, delete,
//   search and clear. Exactly one result follows per transaction: done is high
//   for one cycle while status, entry_count, smallest and largest are valid.
//   The receiver cannot stall; the result is simply presented for that cycle.
//   A transaction walks the entry store one entry per cycle through a single
//   compare unit and a registered read of the store. Clear, and
//   insert/delete/search on a full or empty store, go straight to the
//   report; insert walks down from the top entry, delete and search up from
//   the bottom. busy is high from acceptance until the result is presented;
//   a new transaction can be accepted in the cycle done is high.
//   Reset empties the store (count zero) with no clearing pass; only entries
//   below the count are ever used.

module sorted_list_engine #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [1:0]                        action,
    input  logic [31:0]                       item_value,
    output logic                              busy,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
    output logic [sle_pkg::RESULT_WIDTH-1:0]  smallest,
    output logic [sle_pkg::RESULT_WIDTH-1:0]  largest
);

    localparam int AW = $clog2(CAPACITY);

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;

    sle_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .item_value  (item_value),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .smallest    (smallest),
        .largest     (largest),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    sle_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### design/sle_mem.sv
`timescale 1ns / 1ps
// Entry store of the sorted list engine: one write port, one read port with
// registered read data. Depends on nothing.

module sle_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/sle_seq.sv
`timescale 1ns / 1ps
// Sequencer of the sorted list engine: walks the entry store one entry per cycle
// through a single shared compare unit and keeps count, smallest and largest.
// Depends on sle_pkg.

module sle_seq #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [1:0]                        action,
    input  logic [31:0]                       item_value,
    output logic                              busy,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
    output logic [sle_pkg::RESULT_WIDTH-1:0]  smallest,
    output logic [sle_pkg::RESULT_WIDTH-1:0]  largest,
    output logic                              wr_en,
    output logic [$clog2(CAPACITY)-1:0]       wr_addr,
    output logic [VALUE_WIDTH-1:0]            wr_data,
    output logic [$clog2(CAPACITY)-1:0]       rd_addr,
    input  logic [VALUE_WIDTH-1:0]            rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = sle_pkg::RESULT_WIDTH;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    sle_pkg::state_t  state_reg, state_next;
    sle_pkg::action_t act_reg, act_next;
    sle_pkg::status_t st_reg, st_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [VALUE_WIDTH-1:0] min_reg, min_next;
    logic [VALUE_WIDTH-1:0] max_reg, max_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [VALUE_WIDTH-1:0] prev_reg, prev_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   found_reg, found_next;

    logic                   done_reg, done_next;
    sle_pkg::status_t       ost_reg, ost_next;
    logic [CW-1:0]          ocount_reg, ocount_next;
    logic [RW-1:0]          omin_reg, omin_next;
    logic [RW-1:0]          omax_reg, omax_next;

    logic [VALUE_WIDTH-1:0] in_val;
    logic                   data_lt;
    logic                   data_eq;
    logic                   last;

    // The one compare unit shared by every step of the walk.
    assign data_lt = rd_data < val_reg;
    assign data_eq = rd_data == val_reg;
    assign last    = CW'(idx_reg) == (count_reg - CW'(1));
    assign in_val  = VALUE_WIDTH'(item_value);

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        st_next     = st_reg;
        count_next  = count_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        val_next    = val_reg;
        prev_next   = prev_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        done_next   = 1'b0;
        ost_next    = ost_reg;
        ocount_next = ocount_reg;
        omin_next   = omin_reg;
        omax_next   = omax_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_data;
        rd_addr     = idx_reg;

        case (state_reg)
            sle_pkg::S_IDLE:
            begin
                if (start)
                begin
                    val_next   = in_val;
                    act_next   = sle_pkg::action_t'(action);
                    found_next = 1'b0;
                    st_next    = sle_pkg::ST_OK;
                    state_next = sle_pkg::S_REPORT;
                    case (sle_pkg::action_t'(action))
                        sle_pkg::ACT_INSERT:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                st_next = sle_pkg::ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = in_val;
                                count_next = CW'(1);
                                min_next   = in_val;
                                max_next   = in_val;
                            end
                            else
                            begin
                                // Walk down from the top entry, moving each entry not below the new value up.
                                rd_addr    = AW'(count_reg - CW'(1));
                                idx_next   = AW'(count_reg - CW'(1));
                                state_next = sle_pkg::S_INS;
                            end
                        end
                        sle_pkg::ACT_DELETE, sle_pkg::ACT_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = (sle_pkg::action_t'(action) == sle_pkg::ACT_DELETE) ?
                                          sle_pkg::ST_EMPTY : sle_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = sle_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                            min_next   = '0;
                            max_next   = '0;
                        end
                    endcase
                end
            end

            sle_pkg::S_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                if (!data_lt)
                begin
                    wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = sle_pkg::S_PUT;
                    end
                    else
                    begin
                        rd_addr  = idx_reg - AW'(1);
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    wr_data    = val_reg;
                    count_next = count_reg + CW'(1);
                    if (last)
                    begin
                        max_next = val_reg;
                    end
                    state_next = sle_pkg::S_REPORT;
                end
            end

            sle_pkg::S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = val_reg;
                min_next   = val_reg;
                count_next = count_reg + CW'(1);
                state_next = sle_pkg::S_REPORT;
            end

            sle_pkg::S_SCAN:
            begin
                prev_next = rd_data;
                rd_addr   = idx_reg + AW'(1);
                idx_next  = idx_reg + AW'(1);
                if (found_reg)
                begin
                    // Close the gap: each later entry moves down one place.
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - AW'(1);
                    wr_data = rd_data;
                    if (idx_reg == AW'(1))
                    begin
                        min_next = rd_data;
                    end
                    if (last)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = sle_pkg::S_REPORT;
                    end
                end
                else if (data_lt)
                begin
                    if (last)
                    begin
                        st_next    = sle_pkg::ST_NOT_FOUND;
                        state_next = sle_pkg::S_REPORT;
                    end
                end
                else if (data_eq)
                begin
                    if (act_reg == sle_pkg::ACT_SEARCH)
                    begin
                        state_next = sle_pkg::S_REPORT;
                    end
                    else if (last)
                    begin
                        // The top entry goes; the one below it becomes the largest.
                        count_next = count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            min_next = '0;
                            max_next = '0;
                        end
                        else
                        begin
                            max_next = prev_reg;
                        end
                        state_next = sle_pkg::S_REPORT;
                    end
                    else
                    begin
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    st_next    = sle_pkg::ST_NOT_FOUND;
                    state_next = sle_pkg::S_REPORT;
                end
            end

            sle_pkg::S_REPORT:
            begin
                done_next   = 1'b1;
                ost_next    = st_reg;
                ocount_next = count_reg;
                omin_next   = RW'(min_reg);
                omax_next   = RW'(max_reg);
                state_next  = sle_pkg::S_IDLE;
            end

            default:
            begin
                state_next = sle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sle_pkg::S_IDLE;
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        st_reg     <= st_next;
        val_reg    <= val_next;
        prev_reg   <= prev_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        ost_reg    <= ost_next;
        ocount_reg <= ocount_next;
        omin_reg   <= omin_next;
        omax_reg   <= omax_next;
    end

    assign busy        = state_reg != sle_pkg::S_IDLE;
    assign done        = done_reg;
    assign status      = ost_reg;
    assign entry_count = ocount_reg;
    assign smallest    = omin_reg;
    assign largest     = omax_reg;

endmodule
